// ----- rtl/dense_id_assigner_core_assert.svh -----
// Assertion macros used by the RTL of the dense ID assigner core.
`ifndef DENSE_ID_ASSIGNER_CORE_ASSERT_SVH
`define DENSE_ID_ASSIGNER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
`define DIA_ASSERT(name, prop, clk, rstn) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("dense ID assigner assertion failed");
`define DIA_ASSERT_NR(name, prop, clk) \
  name: assert property (@(posedge clk) prop) \
    else $error("dense ID assigner assertion failed");
`else
`define DIA_ASSERT(name, prop, clk, rstn)
`define DIA_ASSERT_NR(name, prop, clk)
`endif

`endif

// ----- rtl/dia_pkg.sv -----
package dia_pkg;

  localparam int unsigned KeyW = 64;
  localparam int unsigned NumW = 10;
  localparam int unsigned LimW = 11;

  localparam int unsigned TableCapacityDef = 1024;
  localparam logic [LimW-1:0] LimitReset = 11'd1024;

endpackage

// ----- rtl/dense_id_assigner_core.sv -----
// Channel  | Direction | Handshake              | Payload
// ---------+-----------+------------------------+-------------------------------------------
// cfg      | in        | cfg_we_i               | cfg_wdata_i (partition limit)
// in       | in        | in_valid_i/in_ready_o  | in_key_value_i
// out      | out       | out_valid_o/out_ready_i| out_dense_number_o, out_newly_added_o,
//          |           |                        | out_overflow_o
//
// A lookup compares the stored keys in number order and stops at the first hit or after the
// last of the N >= 1 stored keys; on an empty table it goes straight to the miss.
// The key memory is read one entry per cycle through its registered port into one 64-bit
// comparator. Entries fill in number order, so the fill count marks the valid ones and reset
// needs no clearing pass. in_ready_o is high only while no item is in work. A finished item
// waits in a result stage while out_ready_i holds back the item in the output register.
`include "dense_id_assigner_core_assert.svh"

module dense_id_assigner_core #(
  parameter int unsigned TableCapacity = dia_pkg::TableCapacityDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [dia_pkg::LimW-1:0]  cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [dia_pkg::KeyW-1:0]  in_key_value_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [dia_pkg::NumW-1:0]  out_dense_number_o,
  output logic                      out_newly_added_o,
  output logic                      out_overflow_o
);

  localparam int unsigned AddrW = (TableCapacity > 1) ? $clog2(TableCapacity) : 1;
  localparam int unsigned CntW  = $clog2(TableCapacity + 1);
  localparam int unsigned CmpW  = (CntW > dia_pkg::LimW) ? CntW : dia_pkg::LimW;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StDone
  } state_e;

  state_e                   state_q;
  logic [CntW-1:0]          count_q;
  logic [dia_pkg::LimW-1:0] limit_q;
  logic [dia_pkg::KeyW-1:0] key_q;
  logic [CntW-1:0]          rd_addr_q;
  logic                     cmp_v_q;
  logic [CntW-1:0]          cmp_idx_q;
  logic [dia_pkg::NumW-1:0] res_num_q;
  logic                     res_new_q;
  logic                     res_ovf_q;
  logic                     out_valid_q;
  logic [dia_pkg::NumW-1:0] out_num_q;
  logic                     out_new_q;
  logic                     out_ovf_q;

  logic [dia_pkg::KeyW-1:0] rd_data;
  logic                     issue;
  logic                     hit;
  logic                     miss;
  logic                     can_insert;
  logic                     mem_we;

  assign issue      = (state_q == StScan) && (rd_addr_q < count_q);
  assign hit        = cmp_v_q && (rd_data == key_q);
  assign miss       = (state_q == StScan) && !cmp_v_q && !issue;
  // The limit saturates at the table capacity.
  assign can_insert = (CmpW'(count_q) < CmpW'(limit_q)) &&
                      (count_q < CntW'(TableCapacity));
  assign mem_we     = miss && can_insert;

  dia_key_mem #(
    .Depth (TableCapacity)
  ) u_key_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (count_q[AddrW-1:0]),
    .wdata_i (key_q),
    .raddr_i (rd_addr_q[AddrW-1:0]),
    .rdata_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      limit_q     <= dia_pkg::LimitReset;
      key_q       <= '0;
      rd_addr_q   <= '0;
      cmp_v_q     <= 1'b0;
      cmp_idx_q   <= '0;
      res_num_q   <= '0;
      res_new_q   <= 1'b0;
      res_ovf_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_num_q   <= '0;
      out_new_q   <= 1'b0;
      out_ovf_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (out_valid_q && out_ready_i && (state_q != StDone)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            key_q     <= in_key_value_i;
            rd_addr_q <= '0;
            cmp_v_q   <= 1'b0;
            state_q   <= StScan;
          end
        end
        StScan: begin
          // Read data for an address lands in the cycle after it is issued.
          cmp_v_q   <= issue && !hit;
          cmp_idx_q <= rd_addr_q;
          if (issue) begin
            rd_addr_q <= rd_addr_q + 1'b1;
          end
          if (hit) begin
            res_num_q <= dia_pkg::NumW'(cmp_idx_q);
            res_new_q <= 1'b0;
            res_ovf_q <= 1'b0;
            state_q   <= StDone;
          end else if (miss) begin
            if (can_insert) begin
              res_num_q <= dia_pkg::NumW'(count_q);
              res_new_q <= 1'b1;
              res_ovf_q <= 1'b0;
              count_q   <= count_q + 1'b1;
            end else begin
              res_num_q <= '0;
              res_new_q <= 1'b0;
              res_ovf_q <= 1'b1;
            end
            state_q <= StDone;
          end
        end
        StDone: begin
          // The output register is loaded when empty or when its item leaves this cycle.
          if (!out_valid_q || out_ready_i) begin
            out_num_q   <= res_num_q;
            out_new_q   <= res_new_q;
            out_ovf_q   <= res_ovf_q;
            out_valid_q <= 1'b1;
            state_q     <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign in_ready_o         = (state_q == StIdle);
  assign out_valid_o        = out_valid_q;
  assign out_dense_number_o = out_num_q;
  assign out_newly_added_o  = out_new_q;
  assign out_overflow_o     = out_ovf_q;

  `DIA_ASSERT(a_count_bounded, count_q <= CntW'(TableCapacity), clk_i, rst_ni)
  `DIA_ASSERT(a_count_steps,
              1'b1 |=> (count_q == $past(count_q) || count_q == $past(count_q) + CntW'(1)),
              clk_i, rst_ni)
  `DIA_ASSERT(a_busy_after_accept, in_valid_i && in_ready_o |=> !in_ready_o, clk_i, rst_ni)
  `DIA_ASSERT_NR(a_overflow_clean,
                 !rst_ni || !out_valid_o || !out_overflow_o ||
                 (out_dense_number_o == '0 && !out_newly_added_o), clk_i)

endmodule

// ----- rtl/dia_key_mem.sv -----
module dia_key_mem #(
  parameter int unsigned Depth = dia_pkg::TableCapacityDef,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [AddrW-1:0]          waddr_i,
  input  logic [dia_pkg::KeyW-1:0]  wdata_i,
  input  logic [AddrW-1:0]          raddr_i,
  output logic [dia_pkg::KeyW-1:0]  rdata_o
);

  logic [dia_pkg::KeyW-1:0] mem_q [Depth];
  logic [dia_pkg::KeyW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
